### rtl/lzge_pkg.sv
// shared constants and types for the lz77 greedy match encoder
package lzge_pkg;

	localparam int WINDOW   = 256;
	localparam int DIST_W   = $clog2(WINDOW + 1);
	localparam int CMP_W    = (DIST_W > 9) ? DIST_W : 9;
	localparam int GRP      = 16;
	localparam int GRP_W    = $clog2(GRP);
	localparam int NGRP     = (WINDOW + GRP - 1) / GRP;
	localparam int PAD_W    = NGRP * GRP;
	localparam int LEN_W    = 8;
	localparam int WS_W     = 9;
	localparam int OUT_D_W  = 9;
	localparam logic [LEN_W-1:0] MAX_LEN = 8'd255;

	// control handed to every cell of the chain
	typedef struct packed {
		logic [7:0]        byte_v;
		logic [LEN_W-1:0]  len;
		logic [DIST_W-1:0] lim;
		logic              len_zero;
		logic              len_ok;
		logic              eval;
		logic              shift;
		logic              load_live;
		logic              clear_live;
	} lzge_ctl_t;

	// summary of the live and extending candidates
	typedef struct packed {
		logic              any;
		logic [DIST_W-1:0] oldest;
	} lzge_red_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EVAL   = 4'b0010,
		ST_TREE   = 4'b0100,
		ST_DECIDE = 4'b1000
	} lzge_state_t;

endpackage

### rtl/lzge_cell.sv
// one distance of the window: history byte, live flag and compare
module lzge_cell
	import lzge_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lzge_ctl_t         ctl,
	input  logic [DIST_W-1:0] offset,
	input  logic [7:0]        hist_prev,
	output logic [7:0]        hist,
	output logic              live,
	output logic              ext
);

	logic [7:0] hist_q;
	logic       live_q;
	logic       ext_q;
	logic       cand;
	logic       ext_w;

	always_comb begin
		cand  = ctl.len_zero ? (offset <= ctl.lim) : live_q;
		ext_w = cand && (CMP_W'(ctl.len) < CMP_W'(offset)) && ctl.len_ok
			&& (hist_q == ctl.byte_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (ctl.load_live) begin
			live_q <= ext_q;
		end else if (ctl.clear_live) begin
			live_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			ext_q <= ext_w;
		end
		if (ctl.shift) begin
			hist_q <= hist_prev;
		end
	end

	assign hist = hist_q;
	assign live = live_q;
	assign ext  = ext_q;

endmodule

### rtl/lzge_reduce.sv
// registered group tree: any extending candidate and oldest live distance
module lzge_reduce
	import lzge_pkg::*;
(
	input  logic              clk,
	input  logic [WINDOW-1:0] ext_vec,
	input  logic [WINDOW-1:0] live_vec,
	output lzge_red_t         red
);

	logic [PAD_W-1:0] ext_pad;
	logic [PAD_W-1:0] live_pad;
	logic [NGRP-1:0]  grp_any_s1;
	logic [NGRP-1:0]  grp_live_s1;
	logic [GRP_W-1:0] grp_top_s1 [NGRP];

	assign ext_pad  = PAD_W'(ext_vec);
	assign live_pad = PAD_W'(live_vec);

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		logic [GRP_W-1:0] top;

		always_comb begin
			top = '0;
			for (int j = 0; j < GRP; j++) begin
				if (live_pad[g*GRP + j]) begin
					top = GRP_W'(j);
				end
			end
		end

		always_ff @(posedge clk) begin
			grp_any_s1[g]  <= |ext_pad[g*GRP +: GRP];
			grp_live_s1[g] <= |live_pad[g*GRP +: GRP];
			grp_top_s1[g]  <= top;
		end
	end

	// highest live group holds the oldest candidate
	always_comb begin
		red.any    = |grp_any_s1;
		red.oldest = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp_live_s1[g]) begin
				red.oldest = DIST_W'(g * GRP) + DIST_W'(grp_top_s1[g]) + DIST_W'(1);
			end
		end
	end

endmodule

### rtl/lz77_greedy_match_encoder.sv
// Greedy LZ77 encoder: one byte in, (distance, length, literal) tokens out.
// Each accepted byte goes through acceptance, a compare in every cell of
// the window chain, a registered reduction over groups of 16 cells, and the
// decision that either absorbs the byte into the open match or loads a token
// into the output register. The next byte is taken once the decision is made;
// a token waiting at the output only holds back a later decision that must
// emit. Matches never overlap the current position, stop at 255 bytes, and
// the byte marked last always closes a token and clears the history.
module lz77_greedy_match_encoder
	import lzge_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [WS_W-1:0]  cfg_wdata,      // largest distance searched
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,        // [7:0] data byte
	input  logic             s_tlast,        // last byte of the stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,        // [8:0] distance, [16:9] length,
	                                         // [24:17] literal byte, [31:25] zero
	output logic             m_tlast         // last token of the stream
);

	lzge_state_t       state_q;
	logic [WS_W-1:0]   window_q;
	logic [LEN_W-1:0]  len_q;
	logic [DIST_W-1:0] seen_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;
	logic              out_last_q;

	lzge_ctl_t         ctl;
	lzge_red_t         red;
	logic [CMP_W-1:0]  lim_w;
	logic              emit;
	logic              advance;
	logic [7:0]        hist_chain [WINDOW];
	logic [WINDOW-1:0] ext_vec;
	logic [WINDOW-1:0] live_vec;

	always_comb begin
		lim_w = CMP_W'(window_q);
		if (lim_w > CMP_W'(WINDOW)) begin
			lim_w = CMP_W'(WINDOW);
		end
		if (lim_w > CMP_W'(seen_q)) begin
			lim_w = CMP_W'(seen_q);
		end
	end

	assign emit    = !(red.any && !last_q);
	assign advance = (state_q == ST_DECIDE) && !(emit && out_valid_q && !m_tready);

	always_comb begin
		ctl.byte_v     = byte_q;
		ctl.len        = len_q;
		ctl.lim        = DIST_W'(lim_w);
		ctl.len_zero   = (len_q == '0);
		ctl.len_ok     = (len_q != MAX_LEN);
		ctl.eval       = (state_q == ST_EVAL);
		ctl.shift      = advance && !(emit && last_q);
		ctl.load_live  = advance && !emit;
		ctl.clear_live = advance && emit;
	end

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic [7:0] prev;
		if (i == 0) begin : g_head
			assign prev = byte_q;
		end else begin : g_body
			assign prev = hist_chain[i-1];
		end
		lzge_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.offset    (DIST_W'(i + 1)),
			.hist_prev (prev),
			.hist      (hist_chain[i]),
			.live      (live_vec[i]),
			.ext       (ext_vec[i])
		);
	end

	lzge_reduce u_reduce (
		.clk      (clk),
		.ext_vec  (ext_vec),
		.live_vec (live_vec),
		.red      (red)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WS_W'(256);
			len_q       <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_TREE;
				end
				ST_TREE: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (advance) begin
						state_q <= ST_IDLE;
						if (!emit) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							len_q       <= '0;
							out_valid_q <= 1'b1;
						end
						if (emit && last_q) begin
							seen_q <= '0;
						end else if (seen_q != DIST_W'(WINDOW)) begin
							seen_q <= seen_q + DIST_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_q <= s_tdata;
			last_q <= s_tlast;
		end
		if (advance && emit) begin
			out_data_q <= {7'd0, byte_q, len_q,
				(len_q != '0) ? OUT_D_W'(red.oldest) : OUT_D_W'(0)};
			out_last_q <= last_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

### rtl/lzge_checker.sv
// port-level checks for the lz77 greedy match encoder, bound to the top level
module lzge_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// a token has a match length exactly when it has a distance
	a_len_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[16:9] == 8'd0) == (m_tdata[8:0] == 9'd0)))
		else $error("match length and distance disagree");

	// matches never overlap the current position
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[16:9]} <= m_tdata[8:0]))
		else $error("match longer than its distance");

	// a byte is worked on before the next one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

endmodule

bind lz77_greedy_match_encoder lzge_checker u_lzge_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

### tb/tb.sv
// self-checking testbench for the lz77 greedy match encoder, with a token predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lzge_pkg::*;

	typedef struct packed {
		logic [OUT_D_W-1:0] offs;
		logic [LEN_W-1:0]   len;
		logic [7:0]         lit;
		logic               fin;
	} token_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} byte_item_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cfg_we    = 1'b0;
	logic [WS_W-1:0] cfg_wdata = '0;
	logic            s_tvalid  = 1'b0;
	logic [7:0]      s_tdata   = '0;
	logic            s_tlast   = 1'b0;
	logic            m_tready  = 1'b0;
	logic            s_tready;
	logic            m_tvalid;
	logic [31:0]     m_tdata;
	logic            m_tlast;

	lz77_greedy_match_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state
	logic [7:0]     hist_mem [WINDOW];
	logic [WINDOW:0] live_dist;
	int unsigned    hist_wp;
	int unsigned    run_len;
	int unsigned    seen_cnt;
	int unsigned    win_cfg = 256;

	byte_item_t bytes_to_send [$];
	token_t     expected_tokens [$];
	int         in_gap    = 0;
	int         out_stall = 0;
	int         errors    = 0;
	bit         calm      = 1'b0;

	function automatic void clear_history();
		foreach (hist_mem[i])
			hist_mem[i] = '0;
		live_dist = '0;
		hist_wp   = 0;
		run_len   = 0;
		seen_cnt  = 0;
	endfunction

	function automatic void push_hist(input logic [7:0] b);
		hist_mem[hist_wp] = b;
		hist_wp = (hist_wp + 1) % WINDOW;
		if (seen_cnt < WINDOW)
			seen_cnt++;
	endfunction

	// returns 1 when the byte closes a token
	function automatic bit encode_byte(input logic [7:0] b, input logic fin, output token_t tok);
		int unsigned     lim;
		int unsigned     oldest;
		logic [WINDOW:0] ext_dist;
		bit              cand;
		tok = '0;
		lim = win_cfg;
		if (lim > WINDOW)
			lim = WINDOW;
		if (lim > seen_cnt)
			lim = seen_cnt;
		ext_dist = '0;
		for (int d = 1; d <= WINDOW; d++) begin
			cand = (run_len == 0) ? (d <= lim) : live_dist[d];
			ext_dist[d] = cand && run_len < d && run_len < MAX_LEN
				&& hist_mem[(hist_wp + WINDOW - d) % WINDOW] == b;
		end
		if (ext_dist != '0 && !fin) begin
			live_dist = ext_dist;
			run_len++;
			push_hist(b);
			return 1'b0;
		end
		// oldest live distance wins
		oldest = 0;
		if (run_len > 0)
			for (int d = 1; d <= WINDOW; d++)
				if (live_dist[d])
					oldest = d;
		tok.offs = OUT_D_W'(oldest);
		tok.len  = LEN_W'(run_len);
		tok.lit  = b;
		tok.fin  = fin;
		if (fin) begin
			clear_history();
		end else begin
			push_hist(b);
			live_dist = '0;
			run_len   = 0;
		end
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	// byte driver
	always @(posedge clk) begin : drive
		byte_item_t it;
		token_t     tok;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (encode_byte(s_tdata, s_tlast, tok))
					expected_tokens = {expected_tokens, tok};
			end
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (bytes_to_send.size() > 0) begin
					it = bytes_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= it.data;
					s_tlast  <= it.fin;
					in_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// token monitor
	always @(posedge clk) begin : watch
		token_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("token with none expected: %h last %b",
						m_tdata, m_tlast));
				end else begin
					want = expected_tokens.pop_front();
					if (m_tdata[OUT_D_W-1:0] !== want.offs)
						report_mismatch($sformatf("distance %0d, expected %0d",
							m_tdata[OUT_D_W-1:0], want.offs));
					if (m_tdata[OUT_D_W +: LEN_W] !== want.len)
						report_mismatch($sformatf("length %0d, expected %0d",
							m_tdata[OUT_D_W +: LEN_W], want.len));
					if (m_tdata[OUT_D_W+LEN_W +: 8] !== want.lit)
						report_mismatch($sformatf("literal %h, expected %h",
							m_tdata[OUT_D_W+LEN_W +: 8], want.lit));
					if (m_tdata[31:OUT_D_W+LEN_W+8] !== '0)
						report_mismatch($sformatf("pad bits %h not zero",
							m_tdata[31:OUT_D_W+LEN_W+8]));
					if (m_tlast !== want.fin)
						report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.fin));
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					out_stall = pick_gap();
			end
		end
	end

	task automatic queue_one(input logic [7:0] b, input logic fin);
		byte_item_t it;
		it.data = b;
		it.fin  = fin;
		bytes_to_send = {bytes_to_send, it};
	endtask

	// stream mixing copies of earlier bytes with symbols from an alphabet of the given size
	task automatic queue_stream(input int n, input int alpha, input int copy_pct);
		logic [7:0] sb [0:1023];
		logic [7:0] base;
		int         i;
		int         span;
		int         run;
		base = 8'($urandom_range(0, 255));
		i = 0;
		while (i < n) begin
			if (i > 0 && $urandom_range(0, 99) < copy_pct) begin
				span = $urandom_range(1, (i < 300) ? i : 300);
				run  = $urandom_range(1, 24);
				for (int k = 0; k < run && i < n; k++) begin
					sb[i] = sb[i - span];
					i++;
				end
			end else begin
				sb[i] = base ^ 8'($urandom_range(0, alpha - 1));
				i++;
			end
		end
		for (int k = 0; k < n; k++)
			queue_one(sb[k], k == n - 1);
	endtask

	task automatic drain_and_idle();
		while (bytes_to_send.size() > 0 || s_tvalid || expected_tokens.size() > 0)
			@(negedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_window(input logic [WS_W-1:0] v);
		drain_and_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		win_cfg = v;
	endtask

	initial begin : timeout
		#8_000_000;
		$display("lz77_greedy_match_encoder test failed");
		$finish;
	end

	initial begin : stimulus
		int          windows [10];
		int          cnt;
		int          n;
		int          r;
		logic [7:0]  block [256];
		clear_history();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset window: single last byte, runs that cannot overlap, a period-two repeat
		queue_one(8'h00, 1'b1);
		repeat (4) queue_one(8'hFF, 1'b0);
		queue_one(8'hFF, 1'b1);
		repeat (3) begin
			queue_one(8'h12, 1'b0);
			queue_one(8'h34, 1'b0);
		end
		queue_one(8'h56, 1'b1);

		// no candidates at all
		set_window('0);
		repeat (4) queue_one(8'h07, 1'b0);
		queue_one(8'h07, 1'b1);

		// smallest nonzero window
		set_window(9'd1);
		repeat (3) queue_one(8'h03, 1'b0);
		queue_one(8'h09, 1'b0);
		queue_one(8'h03, 1'b1);

		windows = '{511, 256, 2, 0, 37, 1, 1, 200, 256, 300};
		windows[5] = $urandom_range(1, 256);
		foreach (windows[p]) begin
			calm = (p % 3 == 2);
			set_window(WS_W'(windows[p]));
			cnt = 0;
			while (cnt < 48) begin
				n = $urandom_range(1, 40);
				r = $urandom_range(0, 99);
				if (r < 70)
					queue_stream(n, $urandom_range(2, 8), 70);
				else if (r < 85)
					queue_stream(n, 256, 0);
				else
					queue_stream(n, 4, 95);
				cnt += n;
			end
		end

		// a block repeated whole at the window edge runs into the length limit
		calm = 1'b0;
		set_window(9'd256);
		foreach (block[i])
			block[i] = 8'($urandom_range(0, 255));
		repeat (2)
			foreach (block[i])
				queue_one(block[i], 1'b0);
		repeat (5) queue_one(8'($urandom_range(0, 255)), 1'b0);
		queue_one(8'($urandom_range(0, 255)), 1'b1);

		drain_and_idle();
		if (errors == 0)
			$display("lz77_greedy_match_encoder test passed");
		else
			$display("lz77_greedy_match_encoder test failed");
		$finish;
	end

endmodule
